@@ design/sfr_pkg.sv @@
// Shared types and constants for the serial frame receiver.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package sfr_pkg;

    // Sizes of the frame stores
    localparam int MAX_PAYLOAD = 32;
    localparam int MAX_HEADER  = 4;
    localparam int MAX_TRAILER = 4;

    // Field and register widths
    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int HLEN_W     = 3;
    localparam int PLEN_W     = 6;
    localparam int TLEN_W     = 3;
    localparam int FAIL_W     = 16;
    localparam int EVENT_W    = 2;
    localparam int POS_W      = $clog2(MAX_PAYLOAD);
    localparam int HDR_IDX_W  = $clog2(MAX_HEADER);
    localparam int TRL_IDX_W  = $clog2(MAX_TRAILER);

    // Sync bytes that end the hunt in prefilter mode
    localparam logic [BYTE_W-1:0] PRE_BYTE_A = 8'hAB;
    localparam logic [BYTE_W-1:0] PRE_BYTE_B = 8'hCD;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HEADER_BYTES  = 3'd0,
        REG_HEADER_LEN    = 3'd1,
        REG_PAYLOAD_LEN   = 3'd2,
        REG_TRAILER_BYTES = 3'd3,
        REG_TRAILER_LEN   = 3'd4,
        REG_PREFILTER     = 3'd5
    } cfg_reg_t;

    // Result event codes
    typedef enum logic [EVENT_W-1:0] {
        EV_NONE     = 2'd0,
        EV_MISMATCH = 2'd1,
        EV_FRAME    = 2'd2
    } event_t;

    // Frame phase
    typedef enum logic [1:0] {
        PH_HUNT,
        PH_HEADER,
        PH_PAYLOAD,
        PH_TRAILER
    } phase_t;

    // Controller states
    typedef enum logic {
        ST_RUN,
        ST_EMIT
    } ctrl_state_t;

    // Configuration with lengths already clamped to their legal ranges
    typedef struct packed {
        logic [MAX_HEADER-1:0][BYTE_W-1:0]  header_bytes;
        logic [HLEN_W-1:0]                  hlen;
        logic [PLEN_W-1:0]                  plen;
        logic [MAX_TRAILER-1:0][BYTE_W-1:0] trailer_bytes;
        logic [TLEN_W-1:0]                  tlen;
        logic                               prefilter_mode;
    } cfg_t;

    // Controller to datapath
    typedef struct packed {
        logic process;      // commit the step for the pending byte
        logic load_result;  // load the single result of that step
        logic emit_item;    // load the next stored payload byte
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic pending;      // a received byte waits to be processed
        logic out_free;     // output register can take a new item
        logic frame_done;   // pending byte completes a frame
        logic emit_last;    // readout is at the final payload byte
    } dp_status_t;

endpackage

`default_nettype wire

@@ design/sfr_cfg_regs.sv @@
// Configuration register bank of the serial frame receiver.
// Decodes writes and clamps the length fields. Depends on sfr_pkg.
`default_nettype none

module sfr_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]  cfg_data,
    output sfr_pkg::cfg_t                   cfg
);
    import sfr_pkg::*;

    logic [CFG_DATA_W-1:0] header_bytes_reg;
    logic [HLEN_W-1:0]     header_len_reg;
    logic [PLEN_W-1:0]     payload_len_reg;
    logic [CFG_DATA_W-1:0] trailer_bytes_reg;
    logic [TLEN_W-1:0]     trailer_len_reg;
    logic                  prefilter_reg;

    // Writes are always taken
    assign cfg_ready = 1'b1;

    // Decode register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_bytes_reg  <= '0;
            header_len_reg    <= HLEN_W'(1);
            payload_len_reg   <= PLEN_W'(1);
            trailer_bytes_reg <= '0;
            trailer_len_reg   <= '0;
            prefilter_reg     <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_HEADER_BYTES:  header_bytes_reg  <= cfg_data;
                REG_HEADER_LEN:    header_len_reg    <= cfg_data[HLEN_W-1:0];
                REG_PAYLOAD_LEN:   payload_len_reg   <= cfg_data[PLEN_W-1:0];
                REG_TRAILER_BYTES: trailer_bytes_reg <= cfg_data;
                REG_TRAILER_LEN:   trailer_len_reg   <= cfg_data[TLEN_W-1:0];
                REG_PREFILTER:     prefilter_reg     <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // Clamp lengths: header and payload at least one, all at most their store size
    always_comb
    begin
        cfg.header_bytes   = header_bytes_reg;
        cfg.trailer_bytes  = trailer_bytes_reg;
        cfg.prefilter_mode = prefilter_reg;

        if (header_len_reg == '0)
            cfg.hlen = HLEN_W'(1);
        else if (header_len_reg > HLEN_W'(MAX_HEADER))
            cfg.hlen = HLEN_W'(MAX_HEADER);
        else
            cfg.hlen = header_len_reg;

        if (payload_len_reg == '0)
            cfg.plen = PLEN_W'(1);
        else if (payload_len_reg > PLEN_W'(MAX_PAYLOAD))
            cfg.plen = PLEN_W'(MAX_PAYLOAD);
        else
            cfg.plen = payload_len_reg;

        if (trailer_len_reg > TLEN_W'(MAX_TRAILER))
            cfg.tlen = TLEN_W'(MAX_TRAILER);
        else
            cfg.tlen = trailer_len_reg;
    end

endmodule

`default_nettype wire

@@ design/sfr_ctrl.sv @@
// Controller state machine of the serial frame receiver.
// Sequences byte processing and payload readout. Depends on sfr_pkg.
`default_nettype none

module sfr_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sfr_pkg::dp_status_t  status,
    output sfr_pkg::dp_cmd_t     cmd
);
    import sfr_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_RUN;
        else
            state_reg <= state_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_RUN:
            begin
                if (status.pending && status.out_free && status.frame_done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.out_free && status.emit_last)
                    state_next = ST_RUN;
            end
            default: state_next = ST_RUN;
        endcase
    end

    // Commands
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_RUN:
            begin
                cmd.process     = status.pending && status.out_free;
                cmd.load_result = status.pending && status.out_free && !status.frame_done;
            end
            ST_EMIT:
            begin
                cmd.emit_item = status.out_free;
            end
            default: cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ design/sfr_datapath.sv @@
// Datapath of the serial frame receiver: input holding register, frame
// tracker, payload register file and output register. Depends on sfr_pkg.
`default_nettype none

module sfr_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [sfr_pkg::BYTE_W-1:0]    rx_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [sfr_pkg::EVENT_W-1:0]   event_res,
    output logic [sfr_pkg::BYTE_W-1:0]    payload_byte,
    output logic [sfr_pkg::POS_W-1:0]     byte_index,
    output logic                          last,
    output logic [sfr_pkg::FAIL_W-1:0]    fail_count,
    input  sfr_pkg::cfg_t                 cfg,
    input  sfr_pkg::dp_cmd_t              cmd,
    output sfr_pkg::dp_status_t           status
);
    import sfr_pkg::*;

    // Input holding register
    logic              pend_reg;
    logic [BYTE_W-1:0] byte_reg;

    // Frame tracking
    phase_t            phase_reg;
    phase_t            phase_next;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic [FAIL_W-1:0] fail_reg;
    logic [FAIL_W-1:0] fail_next;
    logic [POS_W-1:0]  emit_idx_reg;
    logic [BYTE_W-1:0] payload_store_reg [MAX_PAYLOAD];

    // Output register
    logic              out_valid_reg;
    event_t            out_event_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic [POS_W-1:0]  out_idx_reg;
    logic              out_last_reg;
    logic [FAIL_W-1:0] out_fail_reg;

    // Step decode
    logic              mismatch;
    logic              frame_done;
    logic              store_we;
    logic              advance;
    logic [PLEN_W-1:0] pos_inc;
    logic [BYTE_W-1:0] hdr_exp;
    logic [BYTE_W-1:0] trl_exp;
    logic [PLEN_W-1:0] emit_inc;

    assign in_ready = !pend_reg;

    // Capture a byte; release it once processed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= 1'b0;
        else if (in_valid && in_ready)
            pend_reg <= 1'b1;
        else if (cmd.process)
            pend_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            byte_reg <= rx_byte;
    end

    // Decide the step for the pending byte
    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        fail_next  = fail_reg;
        mismatch   = 1'b0;
        frame_done = 1'b0;
        store_we   = 1'b0;
        advance    = 1'b0;
        pos_inc    = PLEN_W'(pos_reg) + PLEN_W'(1);
        hdr_exp    = cfg.header_bytes[pos_reg[HDR_IDX_W-1:0]];
        trl_exp    = cfg.trailer_bytes[pos_reg[TRL_IDX_W-1:0]];

        unique case (phase_reg)
            PH_HUNT:
            begin
                if (cfg.prefilter_mode)
                    advance = (byte_reg == PRE_BYTE_A) || (byte_reg == PRE_BYTE_B);
                else if (byte_reg != cfg.header_bytes[0])
                    mismatch = 1'b1;
                else
                    advance = 1'b1;

                if (advance)
                begin
                    if (cfg.hlen <= HLEN_W'(1))
                    begin
                        phase_next = PH_PAYLOAD;
                        pos_next   = '0;
                    end
                    else
                    begin
                        phase_next = PH_HEADER;
                        pos_next   = POS_W'(1);
                    end
                end
            end
            PH_HEADER:
            begin
                if (byte_reg != hdr_exp)
                    mismatch = 1'b1;
                else if (pos_inc >= PLEN_W'(cfg.hlen))
                begin
                    phase_next = PH_PAYLOAD;
                    pos_next   = '0;
                end
                else
                    pos_next = POS_W'(pos_inc);
            end
            PH_PAYLOAD:
            begin
                store_we = 1'b1;
                if (pos_inc >= cfg.plen)
                begin
                    pos_next = '0;
                    if (cfg.tlen == '0)
                        frame_done = 1'b1;
                    else
                        phase_next = PH_TRAILER;
                end
                else
                    pos_next = POS_W'(pos_inc);
            end
            PH_TRAILER:
            begin
                if (byte_reg != trl_exp)
                    mismatch = 1'b1;
                else if (pos_inc >= PLEN_W'(cfg.tlen))
                    frame_done = 1'b1;
                else
                    pos_next = POS_W'(pos_inc);
            end
            default:
            begin
                phase_next = PH_HUNT;
                pos_next   = '0;
            end
        endcase

        // Drop back to the hunt on a mismatch or a finished frame
        if (mismatch)
        begin
            phase_next = PH_HUNT;
            pos_next   = '0;
            fail_next  = fail_reg + FAIL_W'(1);
        end
        if (frame_done)
        begin
            phase_next = PH_HUNT;
            pos_next   = '0;
            fail_next  = '0;
        end
    end

    // Commit the step; advance the readout index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HUNT;
            pos_reg      <= '0;
            fail_reg     <= '0;
            emit_idx_reg <= '0;
        end
        else if (cmd.process)
        begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            fail_reg     <= fail_next;
            emit_idx_reg <= '0;
        end
        else if (cmd.emit_item)
            emit_idx_reg <= emit_idx_reg + POS_W'(1);
    end

    // Payload register file
    always_ff @(posedge clk)
    begin
        if (cmd.process && store_we)
            payload_store_reg[pos_reg] <= byte_reg;
    end

    assign emit_inc = PLEN_W'(emit_idx_reg) + PLEN_W'(1);

    // Output register: hold until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_result || cmd.emit_item)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            out_event_reg <= mismatch ? EV_MISMATCH : EV_NONE;
            out_byte_reg  <= '0;
            out_idx_reg   <= '0;
            out_last_reg  <= 1'b1;
            out_fail_reg  <= fail_next;
        end
        else if (cmd.emit_item)
        begin
            out_event_reg <= EV_FRAME;
            out_byte_reg  <= payload_store_reg[emit_idx_reg];
            out_idx_reg   <= emit_idx_reg;
            out_last_reg  <= status.emit_last;
            out_fail_reg  <= fail_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign event_res    = out_event_reg;
    assign payload_byte = out_byte_reg;
    assign byte_index   = out_idx_reg;
    assign last         = out_last_reg;
    assign fail_count   = out_fail_reg;

    // Status to the controller
    assign status.pending    = pend_reg;
    assign status.out_free   = !out_valid_reg || out_ready;
    assign status.frame_done = frame_done;
    assign status.emit_last  = emit_inc >= cfg.plen;

endmodule

`default_nettype wire

@@ design/serial_frame_receiver.sv @@
// Top level of the serial frame receiver: configuration bank, controller
// and datapath. Depends on sfr_pkg, sfr_cfg_regs, sfr_ctrl, sfr_datapath.
`default_nettype none

// Byte-serial frame synchroniser. Each received byte is captured into a
// holding register and decided once the output register is free, so one new
// byte can be captured while the previous result still sits in the output
// register. A byte yields one result (nothing happened, or a header/trailer
// mismatch that bumps the wrapping failure count), except the byte that
// completes a frame: it starts a readout of the stored payload from the
// register file, one byte per cycle unless out_ready stalls it, payload_len
// bytes in all, with last on the final byte and the failure count shown as
// zero. During readout the next byte may already be captured; it is decided
// once the readout ends. Configuration is written through its own port, which
// is always ready, and should only be written while no byte is in flight.
module serial_frame_receiver (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [sfr_pkg::BYTE_W-1:0]      rx_byte,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [sfr_pkg::EVENT_W-1:0]     event_res,
    output logic [sfr_pkg::BYTE_W-1:0]      payload_byte,
    output logic [sfr_pkg::POS_W-1:0]       byte_index,
    output logic                            last,
    output logic [sfr_pkg::FAIL_W-1:0]      fail_count,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sfr_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import sfr_pkg::*;

    cfg_t       cfg;
    dp_cmd_t    cmd;
    dp_status_t status;

    sfr_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sfr_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    sfr_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .event_res    (event_res),
        .payload_byte (payload_byte),
        .byte_index   (byte_index),
        .last         (last),
        .fail_count   (fail_count),
        .cfg          (cfg),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

`default_nettype wire

@@ design/sfr_checker.sv @@
// Port-level checks for the serial frame receiver, bound to the top level.
// Depends on sfr_pkg and serial_frame_receiver.
`default_nettype none

module sfr_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [sfr_pkg::EVENT_W-1:0]     event_res,
    input  logic [sfr_pkg::BYTE_W-1:0]      payload_byte,
    input  logic [sfr_pkg::POS_W-1:0]       byte_index,
    input  logic                            last,
    input  logic [sfr_pkg::FAIL_W-1:0]      fail_count
);
    import sfr_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_res)
            && $stable(payload_byte) && $stable(byte_index) && $stable(last)
            && $stable(fail_count))
        else $error("stalled result changed");

    // Payload readout runs without gaps and with consecutive indexes
    a_readout: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && event_res == EV_FRAME && !last
            |=> out_valid && event_res == EV_FRAME
                && byte_index == POS_W'($past(byte_index) + POS_W'(1)))
        else $error("payload readout broken");

    // A good frame clears the failure count
    a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res == EV_FRAME |-> fail_count == '0)
        else $error("failure count not cleared on frame");

    // A non-frame result is a single, empty item
    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res != EV_FRAME
            |-> last && payload_byte == '0 && byte_index == '0)
        else $error("malformed single result");

endmodule

bind serial_frame_receiver sfr_checker u_sfr_checker (.*);

`default_nettype wire
